// ----- sv/dmhc_pkg.sv -----
package dmhc_pkg;

  // Field widths of one beat on either side
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned HITS_W  = 32;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned TOTAL_W = 40;

  // Shared adder width
  localparam int unsigned ALU_W   = 48;

  localparam int unsigned DEFAULT_ENTRIES = 256;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_STATS  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_REM,
    ST_LRD,
    ST_LCHK,
    ST_STORE,
    ST_CLR,
    ST_SRD,
    ST_SADD,
    ST_SAGE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   tag;
    logic [VALUE_W-1:0] value;
    logic [HITS_W-1:0]  hits;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Write controls from the sequencer to the table
  typedef struct packed {
    logic entry_we;
    logic valid_we;
    logic valid_bit;
  } tbl_wr_t;

endpackage

// ----- sv/dmhc_alu.sv -----
module dmhc_alu (
  input  logic [dmhc_pkg::ALU_W-1:0] a,
  input  logic [dmhc_pkg::ALU_W-1:0] b,
  input  logic                       sub,
  output logic [dmhc_pkg::ALU_W:0]   sum
);

  logic [dmhc_pkg::ALU_W-1:0] b_eff;

  // On subtract the top bit is the carry out: set when a >= b
  assign b_eff = sub ? ~b : b;
  assign sum   = {1'b0, a} + {1'b0, b_eff} + {{dmhc_pkg::ALU_W{1'b0}}, sub};

endmodule

// ----- sv/dmhc_table.sv -----
module dmhc_table #(
  parameter int unsigned ENTRIES = dmhc_pkg::DEFAULT_ENTRIES
) (
  input  logic                         clk,
  input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
  output dmhc_pkg::entry_t             rd_entry,
  output logic                         rd_valid,
  input  dmhc_pkg::tbl_wr_t            wr,
  input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
  input  dmhc_pkg::entry_t             wr_entry
);

  dmhc_pkg::entry_t entry_mem [ENTRIES];
  logic             valid_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.entry_we) begin
      entry_mem[wr_addr] <= wr_entry;
    end
    if (wr.valid_we) begin
      valid_mem[wr_addr] <= wr.valid_bit;
    end
    rd_entry <= entry_mem[rd_addr];
    rd_valid <= valid_mem[rd_addr];
  end

endmodule

// ----- sv/direct_mapped_hash_cache_unit.sv -----
// Direct-mapped cache keyed by a 32-bit hash. Each beat on the input side carries a mode in
// s_tuser (lookup, store, clear all, statistics) and one result beat leaves for every input
// beat, in order. The slot is key_hash modulo ENTRIES: the low key bits when ENTRIES is a power
// of two, otherwise a reciprocal multiply for the quotient (ST_MOD) and a subtract on the
// shared adder for the remainder (ST_REM), after which a lookup waits in ST_LRD for the table
// read. The block has a single table read port and one 48-bit adder, which the statistics
// walk uses twice per entry (hit sum, then age). s_tready is high only while the block is
// idle, and a finished result waits in the output register. After reset the block sweeps
// every entry of the valid memory with s_tready low. A hit count saturates at all ones; the
// statistics hit sum saturates at 2^40 - 1 and the entry count at 511.
module direct_mapped_hash_cache_unit #(
  parameter int unsigned ENTRIES = dmhc_pkg::DEFAULT_ENTRIES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,   // key_hash[31:0], store_value[63:32], now_ms[111:64]
  input  logic [1:0]   s_tuser,   // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // value_bits[31:0], entry_count[40:32], hit_total[80:41],
                                  // oldest_age_ms[128:81], zero fill[135:129]
  output logic [0:0]   m_tuser    // hit[0]
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam bit          POW2  = ((ENTRIES & (ENTRIES - 1)) == 0);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int unsigned ALU_W = dmhc_pkg::ALU_W;
  localparam int unsigned KEY_W = dmhc_pkg::KEY_W;

  // Rounded-up reciprocal of ENTRIES; with this shift the quotient is exact for any key
  localparam int unsigned RECIP_SH   = KEY_W + IDX_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
  localparam logic [KEY_W:0] RECIP   = RECIP_FULL[KEY_W:0];

  // Input fields
  logic [dmhc_pkg::KEY_W-1:0]   in_key;
  logic [dmhc_pkg::VALUE_W-1:0] in_value;
  logic [dmhc_pkg::STAMP_W-1:0] in_now;
  dmhc_pkg::mode_t              in_mode;

  assign in_key   = s_tdata[31:0];
  assign in_value = s_tdata[63:32];
  assign in_now   = s_tdata[111:64];
  assign in_mode  = dmhc_pkg::mode_t'(s_tuser);

  // Sequencer state
  dmhc_pkg::state_t state, state_next;
  logic             boot, boot_next;
  dmhc_pkg::mode_t  op, op_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [KEY_W-1:0] quot, quot_next;

  // Captured item
  logic [dmhc_pkg::KEY_W-1:0]   key_r;
  logic [dmhc_pkg::VALUE_W-1:0] value_r;
  logic [dmhc_pkg::STAMP_W-1:0] now_r;

  // Statistics accumulators
  logic [dmhc_pkg::COUNT_W-1:0] count, count_next;
  logic [dmhc_pkg::TOTAL_W-1:0] total, total_next;
  logic [dmhc_pkg::STAMP_W-1:0] oldest, oldest_next;

  // Output register
  logic                         out_hit;
  logic [dmhc_pkg::VALUE_W-1:0] out_value;
  logic [dmhc_pkg::COUNT_W-1:0] out_count;
  logic [dmhc_pkg::TOTAL_W-1:0] out_total;
  logic [dmhc_pkg::STAMP_W-1:0] out_oldest;

  // Result load controls
  logic emit;
  logic emit_hit;
  logic emit_stats;
  logic out_free;

  // Table access
  logic [IDX_W-1:0]  rd_addr;
  dmhc_pkg::entry_t  rd_entry;
  logic              rd_valid;
  dmhc_pkg::tbl_wr_t wr;
  logic [IDX_W-1:0]  wr_addr;
  dmhc_pkg::entry_t  wr_entry;

  // Shared adder
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_sub;
  logic [ALU_W:0]   alu_sum;

  // Reciprocal quotient and its product back
  logic [2*KEY_W:0] recip_prod;
  logic [KEY_W-1:0] quot_back;
  logic             lookup_hit;

  assign recip_prod = {{(KEY_W+1){1'b0}}, key_r} * {{KEY_W{1'b0}}, RECIP};
  assign quot_back  = quot * KEY_W'(ENTRIES);
  assign lookup_hit = rd_valid && (rd_entry.tag == key_r);
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == dmhc_pkg::ST_IDLE);

  dmhc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  dmhc_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmhc_pkg::ST_CLR;
      boot  <= 1'b1;
      ptr   <= '0;
    end else begin
      state <= state_next;
      boot  <= boot_next;
      ptr   <= ptr_next;
    end
  end

  // Payload and working registers need no reset
  always_ff @(posedge clk) begin
    op     <= op_next;
    slot   <= slot_next;
    quot   <= quot_next;
    count  <= count_next;
    total  <= total_next;
    oldest <= oldest_next;
    if (s_tvalid && s_tready) begin
      key_r   <= in_key;
      value_r <= in_value;
      now_r   <= in_now;
    end
  end

  // Output register: load on emit, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_hit    <= emit_hit;
      out_value  <= emit_hit ? rd_entry.value : '0;
      out_count  <= emit_stats ? count : '0;
      out_total  <= emit_stats ? total : '0;
      out_oldest <= emit_stats ? oldest : '0;
    end
  end

  assign m_tdata = {7'd0, out_oldest, out_total, out_count, out_value};
  assign m_tuser = out_hit;

  always_comb begin
    state_next  = state;
    boot_next   = boot;
    op_next     = op;
    slot_next   = slot;
    ptr_next    = ptr;
    quot_next   = quot;
    count_next  = count;
    total_next  = total;
    oldest_next = oldest;

    emit       = 1'b0;
    emit_hit   = 1'b0;
    emit_stats = 1'b0;

    rd_addr  = slot;
    wr       = '0;
    wr_addr  = slot;
    wr_entry = rd_entry;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;

    unique case (state)
      dmhc_pkg::ST_IDLE: begin
        // Start the slot read at once when the low key bits are the index
        rd_addr = in_key[IDX_W-1:0];
        if (s_tvalid) begin
          op_next   = in_mode;
          slot_next = POW2 ? in_key[IDX_W-1:0] : '0;
          unique case (in_mode)
            dmhc_pkg::MODE_LOOKUP: begin
              state_next = POW2 ? dmhc_pkg::ST_LCHK : dmhc_pkg::ST_MOD;
            end
            dmhc_pkg::MODE_STORE: begin
              state_next = POW2 ? dmhc_pkg::ST_STORE : dmhc_pkg::ST_MOD;
            end
            dmhc_pkg::MODE_CLEAR: begin
              ptr_next   = '0;
              state_next = dmhc_pkg::ST_CLR;
            end
            dmhc_pkg::MODE_STATS: begin
              ptr_next    = '0;
              count_next  = '0;
              total_next  = '0;
              oldest_next = '0;
              state_next  = dmhc_pkg::ST_SRD;
            end
            default: begin
              state_next = dmhc_pkg::ST_IDLE;
            end
          endcase
        end
      end

      dmhc_pkg::ST_MOD: begin
        // Quotient by reciprocal multiply; the remainder follows on the adder
        quot_next  = KEY_W'(recip_prod >> RECIP_SH);
        state_next = dmhc_pkg::ST_REM;
      end

      dmhc_pkg::ST_REM: begin
        alu_a      = ALU_W'(key_r);
        alu_b      = ALU_W'(quot_back);
        alu_sub    = 1'b1;
        slot_next  = alu_sum[IDX_W-1:0];
        state_next = (op == dmhc_pkg::MODE_LOOKUP) ? dmhc_pkg::ST_LRD : dmhc_pkg::ST_STORE;
      end

      dmhc_pkg::ST_LRD: begin
        state_next = dmhc_pkg::ST_LCHK;
      end

      dmhc_pkg::ST_LCHK: begin
        // Bump the hit count unless it already sits at all ones
        alu_a          = ALU_W'(rd_entry.hits);
        alu_b          = ALU_W'(1);
        wr_entry.hits  = alu_sum[dmhc_pkg::HITS_W-1:0];
        if (out_free) begin
          emit        = 1'b1;
          emit_hit    = lookup_hit;
          wr.entry_we = lookup_hit && (rd_entry.hits != '1);
          state_next  = dmhc_pkg::ST_IDLE;
        end
      end

      dmhc_pkg::ST_STORE: begin
        wr_entry.tag   = key_r;
        wr_entry.value = value_r;
        wr_entry.hits  = '0;
        wr_entry.stamp = now_r;
        if (out_free) begin
          emit         = 1'b1;
          wr.entry_we  = 1'b1;
          wr.valid_we  = 1'b1;
          wr.valid_bit = 1'b1;
          state_next   = dmhc_pkg::ST_IDLE;
        end
      end

      dmhc_pkg::ST_CLR: begin
        // Invalidate one entry a cycle; the reset sweep returns no result
        wr.valid_we = 1'b1;
        wr_addr     = ptr;
        ptr_next    = ptr + IDX_W'(1);
        if (ptr == LAST_IDX) begin
          ptr_next = '0;
          if (boot) begin
            boot_next  = 1'b0;
            state_next = dmhc_pkg::ST_IDLE;
          end else begin
            state_next = dmhc_pkg::ST_FIN;
          end
        end
      end

      dmhc_pkg::ST_SRD: begin
        rd_addr    = ptr;
        state_next = dmhc_pkg::ST_SADD;
      end

      dmhc_pkg::ST_SADD: begin
        rd_addr = ptr;
        alu_a   = ALU_W'(total);
        alu_b   = ALU_W'(rd_entry.hits);
        if (rd_valid) begin
          if (count != '1) begin
            count_next = count + 1'b1;
          end
          if (alu_sum[ALU_W:dmhc_pkg::TOTAL_W] != '0) begin
            total_next = '1;
          end else begin
            total_next = alu_sum[dmhc_pkg::TOTAL_W-1:0];
          end
        end
        state_next = dmhc_pkg::ST_SAGE;
      end

      dmhc_pkg::ST_SAGE: begin
        // Age counts only when the stamp lies strictly in the past
        alu_a   = now_r;
        alu_b   = rd_entry.stamp;
        alu_sub = 1'b1;
        if (rd_valid && alu_sum[ALU_W] && (alu_sum[ALU_W-1:0] > oldest)) begin
          oldest_next = alu_sum[ALU_W-1:0];
        end
        if (ptr == LAST_IDX) begin
          ptr_next   = '0;
          state_next = dmhc_pkg::ST_FIN;
        end else begin
          ptr_next   = ptr + IDX_W'(1);
          rd_addr    = ptr + IDX_W'(1);
          state_next = dmhc_pkg::ST_SADD;
        end
      end

      dmhc_pkg::ST_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_stats = (op == dmhc_pkg::MODE_STATS);
          state_next = dmhc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dmhc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SLOTS        = dmhc_pkg::DEFAULT_ENTRIES;
  localparam int unsigned POOL         = 32;
  localparam int unsigned PHASE_ITEMS  = 560;
  // Receiver hold-off for the backpressure test, in cycles
  localparam int unsigned STALL_CYCLES = 400;
  // Statistics walk is the slowest operation
  localparam int unsigned TAIL_CYCLES  = 2 * SLOTS + 50;
  // Longest honest quiet stretch: reset sweep, or a stall stacked on a walk
  localparam int unsigned QUIET_LIMIT  = 8 * SLOTS + 4000;
  localparam logic [dmhc_pkg::TOTAL_W-1:0] HIT_SUM_MAX = '1;

  // One result beat, unpacked into its fields
  typedef struct packed {
    logic                         hit;
    logic [dmhc_pkg::VALUE_W-1:0] value_bits;
    logic [dmhc_pkg::COUNT_W-1:0] entry_count;
    logic [dmhc_pkg::TOTAL_W-1:0] hit_total;
    logic [dmhc_pkg::STAMP_W-1:0] oldest_age;
  } cache_reply_t;

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata  = '0;                    // key_hash, store_value, now_ms
  logic [1:0]   s_tuser  = dmhc_pkg::MODE_LOOKUP; // mode
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [135:0] m_tdata;                // value_bits, entry_count, hit_total, oldest_age_ms
  logic [0:0]   m_tuser;                // hit

  // Shadow copy of the cache contents, updated at each accepted input beat
  logic                         shadow_valid [SLOTS];
  logic [dmhc_pkg::KEY_W-1:0]   shadow_tag   [SLOTS];
  logic [dmhc_pkg::VALUE_W-1:0] shadow_value [SLOTS];
  logic [dmhc_pkg::HITS_W-1:0]  shadow_hits  [SLOTS];
  logic [dmhc_pkg::STAMP_W-1:0] shadow_stamp [SLOTS];

  cache_reply_t                 replies_due[$];
  logic [dmhc_pkg::KEY_W-1:0]   key_pool [POOL];
  logic [dmhc_pkg::STAMP_W-1:0] clock_ms;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned stall_reqs    = 0;

  direct_mapped_hash_cache_unit #(.ENTRIES(SLOTS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Apply one operation to the shadow table and return the reply it must produce.
  function automatic cache_reply_t apply_cache_op(input dmhc_pkg::mode_t op,
                                                  input logic [dmhc_pkg::KEY_W-1:0] key,
                                                  input logic [dmhc_pkg::VALUE_W-1:0] val,
                                                  input logic [dmhc_pkg::STAMP_W-1:0] now_ms);
    cache_reply_t                 r;
    int unsigned                  slot;
    logic [9:0]                   count;
    logic [dmhc_pkg::TOTAL_W:0]   total;
    logic [dmhc_pkg::STAMP_W-1:0] age;
    r = '0;
    slot = key % SLOTS;
    case (op)
      dmhc_pkg::MODE_LOOKUP: begin
        if (shadow_valid[slot] && shadow_tag[slot] == key) begin
          // Saturate the hit count at all ones
          if (shadow_hits[slot] != '1) shadow_hits[slot] = shadow_hits[slot] + 1'b1;
          r.hit = 1'b1;
          r.value_bits = shadow_value[slot];
        end
      end
      dmhc_pkg::MODE_STORE: begin
        shadow_valid[slot] = 1'b1;
        shadow_tag[slot]   = key;
        shadow_value[slot] = val;
        shadow_hits[slot]  = '0;
        shadow_stamp[slot] = now_ms;
      end
      dmhc_pkg::MODE_CLEAR: begin
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
      end
      default: begin
        count = '0;
        total = '0;
        age   = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_valid[i]) begin
            count = count + 1'b1;
            total = total + shadow_hits[i];
            if (total > HIT_SUM_MAX) total = HIT_SUM_MAX;
            // Only stamps strictly older than now contribute an age
            if (now_ms > shadow_stamp[i] && now_ms - shadow_stamp[i] > age)
              age = now_ms - shadow_stamp[i];
          end
        end
        r.entry_count = (count > 10'd511) ? 9'd511 : count[8:0];
        r.hit_total   = total[dmhc_pkg::TOTAL_W-1:0];
        r.oldest_age  = age;
      end
    endcase
    return r;
  endfunction

  function automatic logic [dmhc_pkg::STAMP_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Random key; half of them land on a few hot slots to force tag conflicts.
  function automatic logic [dmhc_pkg::KEY_W-1:0] fresh_key();
    logic [dmhc_pkg::KEY_W-1:0] k;
    k = $urandom;
    if ($urandom_range(1, 0) == 1) k = k - (k % SLOTS) + $urandom_range(7, 0);
    return k;
  endfunction

  // Offer one input beat, idling at random first; record its reply on accept.
  task automatic send_op(input dmhc_pkg::mode_t op, input logic [dmhc_pkg::KEY_W-1:0] key,
                         input logic [dmhc_pkg::VALUE_W-1:0] val,
                         input logic [dmhc_pkg::STAMP_W-1:0] now_ms);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {now_ms, val, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    replies_due.push_back(apply_cache_op(op, key, val, now_ms));
  endtask

  task automatic wait_replies_drained();
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Mostly lookups and stores on a small key pool so hits and overwrites are
  // frequent; some noise keys, stray times, walks and clears mixed in.
  task automatic send_random_op();
    int unsigned                  pick;
    int unsigned                  idx;
    logic [dmhc_pkg::KEY_W-1:0]   key;
    logic [dmhc_pkg::STAMP_W-1:0] now_ms;
    pick = $urandom_range(999, 0);
    idx  = $urandom_range(POOL - 1, 0);
    clock_ms = clock_ms + $urandom_range(2000, 0);
    now_ms = ($urandom_range(9, 0) == 0) ? rand48() : clock_ms;
    if ($urandom_range(15, 0) == 0) key_pool[idx] = fresh_key();
    key = ($urandom_range(4, 0) == 0) ? dmhc_pkg::KEY_W'($urandom) : key_pool[idx];
    if (pick < 560)      send_op(dmhc_pkg::MODE_LOOKUP, key, $urandom, now_ms);
    else if (pick < 930) send_op(dmhc_pkg::MODE_STORE, key, $urandom, now_ms);
    else if (pick < 985) send_op(dmhc_pkg::MODE_STATS, key, $urandom, now_ms);
    else                 send_op(dmhc_pkg::MODE_CLEAR, key, $urandom, now_ms);
  endtask

  // Field extremes, tag conflicts, hit counting, overwrite, age edge cases, clear.
  task automatic test_directed();
    logic [dmhc_pkg::STAMP_W-1:0] t_max;
    logic [dmhc_pkg::STAMP_W-1:0] t_mid;
    t_max = '1;
    t_mid = 48'h8000_0000_0000;
    send_op(dmhc_pkg::MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, t_max);   // empty table: miss
    send_op(dmhc_pkg::MODE_STATS,  32'hFFFF_FFFF, 32'hFFFF_FFFF, t_max);   // empty: all zero
    send_op(dmhc_pkg::MODE_STORE,  32'h0000_0000, 32'h0000_0000, '0);
    send_op(dmhc_pkg::MODE_STORE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, t_max);
    send_op(dmhc_pkg::MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, '0);
    send_op(dmhc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, '0);
    send_op(dmhc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, t_max);
    send_op(dmhc_pkg::MODE_LOOKUP, 32'h0000_0000 + SLOTS, '0, '0);        // same slot, other tag
    send_op(dmhc_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, '0, '0);                 // same slot, other tag
    send_op(dmhc_pkg::MODE_STATS,  '0, '0, '0);                            // nothing older
    send_op(dmhc_pkg::MODE_STATS,  '0, '0, t_max);                         // widest age
    send_op(dmhc_pkg::MODE_STORE,  32'h0000_0000 + SLOTS, 32'hA5A5_A5A5, 48'd1000); // overwrite
    send_op(dmhc_pkg::MODE_LOOKUP, 32'h0000_0000, '0, '0);
    send_op(dmhc_pkg::MODE_LOOKUP, 32'h0000_0000 + SLOTS, '0, '0);
    send_op(dmhc_pkg::MODE_STATS,  '0, '0, 48'd1000);                      // stamp equal to now
    send_op(dmhc_pkg::MODE_STORE,  32'h1234_5680, 32'h5A5A_5A5A, t_mid);
    send_op(dmhc_pkg::MODE_STATS,  '0, '0, t_mid + 48'd5);
    send_op(dmhc_pkg::MODE_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, t_max);
    send_op(dmhc_pkg::MODE_LOOKUP, 32'h0000_0000 + SLOTS, '0, '0);        // cleared: miss
    send_op(dmhc_pkg::MODE_STATS,  '0, '0, t_max);
    send_op(dmhc_pkg::MODE_STORE,  32'hFFFF_FFFF, 32'h0123_4567, t_mid);
    send_op(dmhc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0);
    send_op(dmhc_pkg::MODE_STATS,  '0, '0, t_mid - 48'd1);                 // stamp newer than now
  endtask

  task automatic test_random_mix(input int unsigned items);
    repeat (items) send_random_op();
  endtask

  // Hold the receiver off while beats keep coming, so the input stalls.
  task automatic test_backpressure();
    stall_reqs++;
    repeat (24) send_random_op();
    s_tvalid <= 1'b0;
    wait_replies_drained();
  endtask

  // Pause the sender until every reply is back, then resume.
  task automatic test_idle_restart();
    repeat (8) send_random_op();
    s_tvalid <= 1'b0;
    wait_replies_drained();
    repeat (8) send_random_op();
  endtask

  // Fill every slot, read some back, walk the full table, then clear it and walk it again.
  task automatic test_full_table();
    logic [dmhc_pkg::KEY_W-1:0] keys [SLOTS];
    logic [dmhc_pkg::KEY_W-1:0] k;
    for (int i = 0; i < SLOTS; i++) begin
      k = $urandom;
      keys[i] = k - (k % SLOTS) + i;
      send_op(dmhc_pkg::MODE_STORE, keys[i], $urandom, clock_ms + i);
    end
    repeat (24) send_op(dmhc_pkg::MODE_LOOKUP, keys[$urandom_range(SLOTS - 1, 0)], $urandom,
                        rand48());
    send_op(dmhc_pkg::MODE_STATS, '0, '0, clock_ms + SLOTS);
    send_op(dmhc_pkg::MODE_CLEAR, '0, '0, '0);
    send_op(dmhc_pkg::MODE_STATS, '0, '0, rand48());
  endtask

  initial begin : run
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    foreach (key_pool[i]) key_pool[i] = fresh_key();
    clock_ms = rand48() >> 2;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 31;
    recv_idle_pct = 64;
    test_directed();
    test_random_mix(PHASE_ITEMS);
    test_backpressure();

    send_idle_pct = 64;
    recv_idle_pct = 31;
    test_random_mix(PHASE_ITEMS);
    test_idle_restart();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_full_table();
    test_random_mix(PHASE_ITEMS);

    // Drop valid, collect the remaining replies, then give stray beats time to show
    s_tvalid <= 1'b0;
    wait_replies_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("direct_mapped_hash_cache_unit regression: pass");
    else
      $display("direct_mapped_hash_cache_unit regression: fail");
    $finish;
  end

  // Drive m_tready: random idling, plus a long hold-off counted here on request.
  initial begin : ready_gen
    int unsigned hold_left;
    int unsigned stall_seen;
    hold_left  = 0;
    stall_seen = 0;
    forever begin
      @(posedge clk);
      if (stall_reqs != stall_seen) begin
        hold_left  = STALL_CYCLES;
        stall_seen = stall_reqs;
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
      if (hold_left != 0) hold_left--;
    end
  end

  task automatic check_field(input string field, input logic [dmhc_pkg::STAMP_W-1:0] want,
                             input logic [dmhc_pkg::STAMP_W-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, seen);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest outstanding reply.
  always @(posedge clk) begin : reply_check
    cache_reply_t seen;
    cache_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = {m_tuser[0], m_tdata[31:0], m_tdata[40:32], m_tdata[80:41], m_tdata[128:81]};
      if (replies_due.size() == 0) begin
        $display("%0t: result beat with nothing outstanding: expected none, actual %p",
                 $time, seen);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        check_field("hit", want.hit, seen.hit);
        check_field("value_bits", want.value_bits, seen.value_bits);
        check_field("entry_count", want.entry_count, seen.entry_count);
        check_field("hit_total", want.hit_total, seen.hit_total);
        check_field("oldest_age_ms", want.oldest_age, seen.oldest_age);
      end
    end
  end

  // Abort when no beat moves on either side for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
      $display("direct_mapped_hash_cache_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
